// ===== hdl/ctws_pkg.sv =====
// ----------------------------------------------------------------------------
// ctws_pkg: shared types and constants of the crank trigger wheel simulator
// Holds the default sizes, the configuration register map with reset values,
// the wheel phase encoding and the configuration bundle.
// ----------------------------------------------------------------------------
package ctws_pkg;

    localparam int CTWS_SAMPLE_BITS   = 12;
    localparam int CTWS_REQUEST_EVERY = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int TOOTH_W    = 6;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DEADBAND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOOTH_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_END      = 3'd4;

    // register reset values
    localparam logic [11:0]        RST_SAMPLE_OFFSET = 12'd50;
    localparam logic [11:0]        RST_RAMP_DEADBAND = 12'd25;
    localparam logic [TOOTH_W-1:0] RST_TOOTH_COUNT   = 6'd21;
    localparam logic [TOOTH_W-1:0] RST_SYNC_START    = 6'd15;
    localparam logic [TOOTH_W-1:0] RST_SYNC_END      = 6'd18;

    typedef enum logic [1:0] {
        PH_TOOTH_LOW  = 2'd0,
        PH_TOOTH_HIGH = 2'd1,
        PH_GAP_LOW    = 2'd2,
        PH_GAP_HIGH   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [11:0]        sample_offset;
        logic [11:0]        ramp_deadband;
        logic [TOOTH_W-1:0] tooth_count;
        logic [TOOTH_W-1:0] sync_start_tooth;
        logic [TOOTH_W-1:0] sync_end_tooth;
    } t_cfg;

endpackage

// ===== hdl/ctws_in_if.sv =====
// ----------------------------------------------------------------------------
// ctws_in_if: tick channel into the wheel simulator
// One transaction is one clock tick, optionally carrying a converter sample.
// ----------------------------------------------------------------------------
interface ctws_in_if
    import ctws_pkg::*;
#(
    parameter int SAMPLE_BITS = CTWS_SAMPLE_BITS
) ();
    logic                   valid;
    logic                   ready;
    logic                   sample_valid;
    logic [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_valid, output sample_value, input ready);
    modport sink   (input valid, input sample_valid, input sample_value, output ready);
endinterface

// ===== hdl/ctws_out_if.sv =====
// ----------------------------------------------------------------------------
// ctws_out_if: waveform channel out of the wheel simulator
// One transaction carries the signal levels after one tick.
// ----------------------------------------------------------------------------
interface ctws_out_if ();
    logic valid;
    logic ready;
    logic crank_level;
    logic sync_level;
    logic sample_request;
    logic running;

    modport source (output valid, output crank_level, output sync_level,
                    output sample_request, output running, input ready);
    modport sink   (input valid, input crank_level, input sync_level,
                    input sample_request, input running, output ready);
endinterface

// ===== hdl/ctws_wheel.sv =====
// ----------------------------------------------------------------------------
// ctws_wheel: wheel state and per-tick update
// Holds the phase counter, tooth index, revolution count and speed ramp, and
// computes the levels after one tick; state commits when i_step is high.
// ----------------------------------------------------------------------------
module ctws_wheel
    import ctws_pkg::*;
#(
    parameter int SAMPLE_BITS   = CTWS_SAMPLE_BITS,
    parameter int REQUEST_EVERY = CTWS_REQUEST_EVERY
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic                   i_sample_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  t_cfg                   i_cfg,
    output logic                   o_crank,
    output logic                   o_sync,
    output logic                   o_req,
    output logic                   o_running
);

    localparam int CMP_W = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
    localparam int PT_W  = SAMPLE_BITS + 2;
    localparam int REV_W = (REQUEST_EVERY > 1) ? $clog2(REQUEST_EVERY) : 1;

    logic                   r_started, n_started;
    logic [SAMPLE_BITS-1:0] r_hp, n_hp;
    logic [SAMPLE_BITS-1:0] r_target, n_target;
    logic [SAMPLE_BITS-1:0] r_latest, n_latest;
    logic                   r_fresh, n_fresh;
    logic [PT_W-1:0]        r_ticks, n_ticks;
    t_phase                 r_phase, n_phase;
    logic [TOOTH_W-1:0]     r_tooth, n_tooth;
    logic [REV_W-1:0]       r_rev, n_rev;
    logic                   r_odd, n_odd;
    logic                   r_crank, n_crank;
    logic                   r_sync, n_sync;
    logic                   rev_begin;

    logic [CMP_W-1:0]       off_ext;
    logic [SAMPLE_BITS-1:0] off;
    logic [CMP_W-1:0]       db_ext;
    logic [PT_W-1:0]        len_raw;
    logic [PT_W-1:0]        phase_len;
    logic [PT_W-1:0]        ticks_inc;
    logic                   phase_done;
    logic [TOOTH_W-1:0]     teeth;
    logic [TOOTH_W-1:0]     tooth_inc;
    logic                   teeth_done;
    logic [REV_W-1:0]       rev_inc;
    logic                   fresh_now;
    logic [SAMPLE_BITS-1:0] latest_now;
    logic [SAMPLE_BITS-1:0] new_target;
    logic [SAMPLE_BITS-1:0] up_diff;
    logic [SAMPLE_BITS-1:0] dn_diff;
    logic [SAMPLE_BITS-1:0] ramped_hp;

    // offset is masked to the sample width
    assign off_ext = CMP_W'(i_cfg.sample_offset);
    assign off     = off_ext[SAMPLE_BITS-1:0];
    assign db_ext  = CMP_W'(i_cfg.ramp_deadband);

    always_comb begin
        case (r_phase)
            PH_GAP_LOW:  len_raw = PT_W'(r_hp) << 1;
            PH_GAP_HIGH: len_raw = PT_W'(r_hp) << 2;
            default:     len_raw = PT_W'(r_hp);
        endcase
    end

    // a phase of zero length lasts one tick
    assign phase_len  = (len_raw == '0) ? PT_W'(1) : len_raw;
    assign ticks_inc  = r_ticks + PT_W'(1);
    assign phase_done = (ticks_inc >= phase_len);

    assign teeth      = (i_cfg.tooth_count == '0) ? TOOTH_W'(1) : i_cfg.tooth_count;
    assign tooth_inc  = r_tooth + TOOTH_W'(1);
    assign teeth_done = (tooth_inc >= teeth) || (tooth_inc == '0);

    assign rev_inc = (r_rev == REV_W'(REQUEST_EVERY - 1)) ? '0 : r_rev + REV_W'(1);

    // a sample on the closing tick counts for this revolution
    assign fresh_now  = i_sample_valid | r_fresh;
    assign latest_now = i_sample_valid ? i_sample_value : r_latest;
    assign new_target = (fresh_now && (latest_now > off)) ? latest_now - off : r_target;

    assign up_diff = new_target - r_hp;
    assign dn_diff = r_hp - new_target;

    always_comb begin
        ramped_hp = r_hp;
        if (new_target > r_hp) begin
            if (CMP_W'(up_diff) > db_ext) begin
                ramped_hp = r_hp + SAMPLE_BITS'(1);
            end
        end else if (r_hp > new_target) begin
            if (CMP_W'(dn_diff) > db_ext) begin
                ramped_hp = r_hp - SAMPLE_BITS'(1);
            end
        end
    end

    // next state
    always_comb begin
        n_started = r_started;
        n_hp      = r_hp;
        n_target  = r_target;
        n_latest  = r_latest;
        n_fresh   = r_fresh;
        n_ticks   = r_ticks;
        n_phase   = r_phase;
        n_tooth   = r_tooth;
        n_rev     = r_rev;
        n_odd     = r_odd;
        n_crank   = r_crank;
        n_sync    = r_sync;
        rev_begin = 1'b0;
        if (!r_started) begin
            if (i_sample_valid && (i_sample_value > off)) begin
                n_started = 1'b1;
                n_hp      = i_sample_value - off;
                rev_begin = 1'b1;
                n_crank   = 1'b0;
                n_phase   = PH_TOOTH_LOW;
                n_ticks   = '0;
                n_tooth   = '0;
            end
        end else begin
            if (i_sample_valid) begin
                n_latest = i_sample_value;
                n_fresh  = 1'b1;
            end
            if (phase_done) begin
                n_ticks = '0;
                case (r_phase)
                    PH_TOOTH_LOW: begin
                        n_crank = 1'b1;
                        n_phase = PH_TOOTH_HIGH;
                    end
                    PH_TOOTH_HIGH: begin
                        n_crank = 1'b0;
                        if (r_odd) begin
                            if (r_tooth == i_cfg.sync_start_tooth) begin
                                n_sync = 1'b1;
                            end else if (r_tooth == i_cfg.sync_end_tooth) begin
                                n_sync = 1'b0;
                            end
                        end
                        n_tooth = tooth_inc;
                        n_phase = teeth_done ? PH_GAP_LOW : PH_TOOTH_LOW;
                    end
                    PH_GAP_LOW: begin
                        n_crank = 1'b1;
                        n_phase = PH_GAP_HIGH;
                    end
                    PH_GAP_HIGH: begin
                        n_rev     = rev_inc;
                        n_odd     = ~r_odd;
                        n_fresh   = 1'b0;
                        n_target  = new_target;
                        n_hp      = ramped_hp;
                        rev_begin = 1'b1;
                        n_crank   = 1'b0;
                        n_phase   = PH_TOOTH_LOW;
                        n_tooth   = '0;
                    end
                    default: begin
                        n_phase = PH_TOOTH_LOW;
                    end
                endcase
            end else begin
                n_ticks = ticks_inc;
            end
        end
    end

    // levels after this tick
    always_comb begin
        o_crank   = n_crank;
        o_sync    = n_sync;
        o_running = n_started;
        o_req     = ~r_started | (rev_begin & (n_rev == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_hp      <= '0;
            r_target  <= '0;
            r_latest  <= '0;
            r_fresh   <= 1'b0;
            r_ticks   <= '0;
            r_phase   <= PH_TOOTH_LOW;
            r_tooth   <= '0;
            r_rev     <= '0;
            r_odd     <= 1'b0;
            r_crank   <= 1'b0;
            r_sync    <= 1'b0;
        end else if (i_step) begin
            r_started <= n_started;
            r_hp      <= n_hp;
            r_target  <= n_target;
            r_latest  <= n_latest;
            r_fresh   <= n_fresh;
            r_ticks   <= n_ticks;
            r_phase   <= n_phase;
            r_tooth   <= n_tooth;
            r_rev     <= n_rev;
            r_odd     <= n_odd;
            r_crank   <= n_crank;
            r_sync    <= n_sync;
        end
    end

`ifndef SYNTHESIS
    a_idle_crank_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> !r_crank && !r_sync)
        else $error("crank or sync active before start");

    a_started_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("running dropped without reset");

    a_ticks_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ticks < phase_len)
        else $error("phase tick count past phase length");

    a_hold_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_ticks) && $stable(r_phase) && $stable(r_hp))
        else $error("wheel state moved without a tick");
`endif

endmodule

// ===== hdl/crank_trigger_wheel_simulator_core.sv =====
// ----------------------------------------------------------------------------
// crank_trigger_wheel_simulator_core: simulated crank trigger wheel
// Turns a stream of clock ticks into crank tooth, cam sync and sample request
// levels, with the wheel speed set and ramped from converter samples.
// ----------------------------------------------------------------------------
// Usage:
//   i_smp carries one transaction per wheel tick; sample_valid marks a tick
//   that also brings a converter reading in sample_value.
//   o_wave returns exactly one transaction per tick with crank_level,
//   sync_level, sample_request and running as they stand after that tick.
//   i_cfg_we / i_cfg_idx / i_cfg_data write the five setup registers
//   (offset, deadband, tooth count, sync start and end tooth); write only
//   while no tick is in flight.
// Timing:
//   An accepted tick is loaded into the input register, and the wheel update
//   then writes its levels into the result register that drives o_wave; the
//   receiver sees a tick only after both registers. One tick is taken per
//   cycle, sustained, while o_wave.ready stays high; the wheel update is a
//   single pass of short logic between those two registers.
// Reset (i_rst_n low, synchronous): registers return to their defaults, the
//   wheel stops and waits for a sample above the offset; both stages empty.
// Stall: while o_wave.ready is low the result register holds and the input
//   register fills; i_smp.ready then drops until the receiver takes a result.
// ----------------------------------------------------------------------------
module crank_trigger_wheel_simulator_core
    import ctws_pkg::*;
#(
    parameter int SAMPLE_BITS   = CTWS_SAMPLE_BITS,
    parameter int REQUEST_EVERY = CTWS_REQUEST_EVERY
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ctws_in_if.sink               i_smp,
    ctws_out_if.source            o_wave,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                   r_cfg;
    logic                   r_s1_vld;
    logic                   r_s1_sv;
    logic [SAMPLE_BITS-1:0] r_s1_val;
    logic                   r_out_vld;
    logic                   r_out_crank;
    logic                   r_out_sync;
    logic                   r_out_req;
    logic                   r_out_run;

    logic                   advance;
    logic                   step;
    logic                   w_crank;
    logic                   w_sync;
    logic                   w_req;
    logic                   w_run;

    // the result slot frees when empty or when the receiver takes it
    assign advance     = ~r_out_vld | o_wave.ready;
    assign step        = r_s1_vld & advance;
    assign i_smp.ready = ~r_s1_vld | advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_offset    <= RST_SAMPLE_OFFSET;
            r_cfg.ramp_deadband    <= RST_RAMP_DEADBAND;
            r_cfg.tooth_count      <= RST_TOOTH_COUNT;
            r_cfg.sync_start_tooth <= RST_SYNC_START;
            r_cfg.sync_end_tooth   <= RST_SYNC_END;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_OFFSET: r_cfg.sample_offset    <= i_cfg_data;
                CFG_RAMP_DEADBAND: r_cfg.ramp_deadband    <= i_cfg_data;
                CFG_TOOTH_COUNT:   r_cfg.tooth_count      <= i_cfg_data[TOOTH_W-1:0];
                CFG_SYNC_START:    r_cfg.sync_start_tooth <= i_cfg_data[TOOTH_W-1:0];
                CFG_SYNC_END:      r_cfg.sync_end_tooth   <= i_cfg_data[TOOTH_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // input stage: hold the accepted tick until the wheel consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_smp.ready) begin
            r_s1_vld <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_s1_sv  <= i_smp.sample_valid;
            r_s1_val <= i_smp.sample_value;
        end
    end

    ctws_wheel #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .REQUEST_EVERY (REQUEST_EVERY)
    ) u_wheel (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_sample_valid (r_s1_sv),
        .i_sample_value (r_s1_val),
        .i_cfg          (r_cfg),
        .o_crank        (w_crank),
        .o_sync         (w_sync),
        .o_req          (w_req),
        .o_running      (w_run)
    );

    // result stage: advance on a tick, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (o_wave.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_crank <= w_crank;
            r_out_sync  <= w_sync;
            r_out_req   <= w_req;
            r_out_run   <= w_run;
        end
    end

    assign o_wave.valid          = r_out_vld;
    assign o_wave.crank_level    = r_out_crank;
    assign o_wave.sync_level     = r_out_sync;
    assign o_wave.sample_request = r_out_req;
    assign o_wave.running        = r_out_run;

`ifndef SYNTHESIS
    a_step_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_vld)
        else $error("tick consumed without a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_wave.ready |-> !step)
        else $error("pending result overwritten");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !step |=> r_s1_vld && $stable(r_s1_val) && $stable(r_s1_sv))
        else $error("queued tick lost");
`endif

endmodule
